### sv/mhpq_pkg.sv
// Package: command and status codes, microcode word layout and the control store.
package mhpq_pkg;

	// heap capacity; position and count fields are sized for it
	localparam int unsigned DEPTH  = 64;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned STEP_W = 4;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_SETKEY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_EMPTY  = 2'd1,
		STATUS_FULL   = 2'd2,
		STATUS_BADPOS = 2'd3
	} status_t;

	// datapath action of one microcode step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_INS_START,
		OP_UP_STEP,
		OP_WRITE_KEY,
		OP_LOAD_VALUE,
		OP_EXT_START,
		OP_EXT_LOAD,
		OP_SET_START,
		OP_DOWN_STEP,
		OP_EMIT
	} op_t;

	// read addresses issued to the heap memory
	typedef enum logic [2:0] {
		RD_NONE,
		RD_ROOT,
		RD_ROOT_LAST,
		RD_PARENT,
		RD_CHILDREN
	} rd_sel_t;

	// sequencing: jump to target when the condition holds, else advance
	typedef enum logic [2:0] {
		BR_NEXT,
		BR_ALWAYS,
		BR_IDX_ZERO,
		BR_KEY_GT_A,
		BR_NO_LEFT,
		BR_CHILD_GT,
		BR_DISPATCH,
		BR_EMIT
	} br_t;

	typedef struct packed {
		op_t     op;
		rd_sel_t rd;
		br_t     br;
		step_t   target;
	} uword_t;

	localparam step_t STEP_IDLE    = 4'd0;
	localparam step_t STEP_INS     = 4'd1;
	localparam step_t STEP_UP_RD   = 4'd2;
	localparam step_t STEP_UP_CMP  = 4'd3;
	localparam step_t STEP_UP_DONE = 4'd4;
	localparam step_t STEP_PK_RD   = 4'd5;
	localparam step_t STEP_PK_LD   = 4'd6;
	localparam step_t STEP_EX_RD   = 4'd7;
	localparam step_t STEP_EX_LD   = 4'd8;
	localparam step_t STEP_SK_IDX  = 4'd9;
	localparam step_t STEP_SK_RD   = 4'd10;
	localparam step_t STEP_SK_CMP  = 4'd11;
	localparam step_t STEP_DN_RD   = 4'd12;
	localparam step_t STEP_DN_CMP  = 4'd13;
	localparam step_t STEP_DN_DONE = 4'd14;
	localparam step_t STEP_OUT     = 4'd15;

	function automatic step_t cmd_entry(input cmd_t cmd);
		step_t s;
		case (cmd)
			CMD_INSERT:  s = STEP_INS;
			CMD_EXTRACT: s = STEP_EX_RD;
			CMD_PEEK:    s = STEP_PK_RD;
			CMD_SETKEY:  s = STEP_SK_IDX;
			default:     s = STEP_OUT;
		endcase
		return s;
	endfunction

	// control store
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		case (step)
			STEP_IDLE:    w = '{OP_ACCEPT,     RD_NONE,      BR_DISPATCH, STEP_IDLE};
			STEP_INS:     w = '{OP_INS_START,  RD_NONE,      BR_NEXT,     STEP_IDLE};
			STEP_UP_RD:   w = '{OP_NONE,       RD_PARENT,    BR_IDX_ZERO, STEP_UP_DONE};
			STEP_UP_CMP:  w = '{OP_UP_STEP,    RD_NONE,      BR_KEY_GT_A, STEP_UP_RD};
			STEP_UP_DONE: w = '{OP_WRITE_KEY,  RD_NONE,      BR_ALWAYS,   STEP_OUT};
			STEP_PK_RD:   w = '{OP_NONE,       RD_ROOT,      BR_NEXT,     STEP_IDLE};
			STEP_PK_LD:   w = '{OP_LOAD_VALUE, RD_NONE,      BR_ALWAYS,   STEP_OUT};
			STEP_EX_RD:   w = '{OP_EXT_START,  RD_ROOT_LAST, BR_NEXT,     STEP_IDLE};
			STEP_EX_LD:   w = '{OP_EXT_LOAD,   RD_NONE,      BR_ALWAYS,   STEP_DN_RD};
			STEP_SK_IDX:  w = '{OP_SET_START,  RD_NONE,      BR_NEXT,     STEP_IDLE};
			STEP_SK_RD:   w = '{OP_NONE,       RD_PARENT,    BR_IDX_ZERO, STEP_DN_RD};
			STEP_SK_CMP:  w = '{OP_UP_STEP,    RD_NONE,      BR_KEY_GT_A, STEP_UP_RD};
			STEP_DN_RD:   w = '{OP_NONE,       RD_CHILDREN,  BR_NO_LEFT,  STEP_DN_DONE};
			STEP_DN_CMP:  w = '{OP_DOWN_STEP,  RD_NONE,      BR_CHILD_GT, STEP_DN_RD};
			STEP_DN_DONE: w = '{OP_WRITE_KEY,  RD_NONE,      BR_NEXT,     STEP_IDLE};
			STEP_OUT:     w = '{OP_EMIT,       RD_NONE,      BR_EMIT,     STEP_IDLE};
			default:      w = '{OP_NONE,       RD_NONE,      BR_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

### sv/max_heap_priority_queue.sv
// Top level: microcoded binary max-heap priority queue with stream ports.
// A rejected command goes straight to the result step; insert, extract and set-key walk the
// heap one level at a time, at most log2(DEPTH) levels, each paced by the registered read of
// the heap memory. One command is in work at a time, and s_tready rises together with
// m_tvalid, so the next input transfer can follow as soon as the reply is offered.
// Reset clears the element count, the step counter and the output valid; the heap
// memory is not cleared, and only entries below the count are ever used.
module max_heap_priority_queue (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] key, [38:32] position, [39] zero
	input  logic [1:0]  s_tuser,   // [1:0] command

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [38:32] count, [39] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned DEPTH = mhpq_pkg::DEPTH;

	// index into the heap memory, count that can hold DEPTH itself,
	// child positions, and a width wide enough to compare count and position
	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned LW   = AW + 2;
	localparam int unsigned CMPW = (CW > mhpq_pkg::POS_W) ? CW : mhpq_pkg::POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// heap storage: one write port, two registered read ports
	mhpq_pkg::key_t mem [DEPTH];
	mhpq_pkg::key_t rd_a_q;
	mhpq_pkg::key_t rd_b_q;
	logic [AW-1:0]  rd_addr_a;
	logic [AW-1:0]  rd_addr_b;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	mhpq_pkg::key_t mem_wdata;

	// sequencer
	mhpq_pkg::step_t  step_q;
	mhpq_pkg::step_t  step_nx;
	mhpq_pkg::step_t  step_inc;
	mhpq_pkg::uword_t uw;

	// datapath registers
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          idx_q;
	mhpq_pkg::key_t         key_q;
	mhpq_pkg::key_t         value_q;
	logic [mhpq_pkg::POS_W-1:0] pos_q;
	mhpq_pkg::status_t      status_q;

	// output register
	logic                   m_tvalid_q;
	mhpq_pkg::key_t         m_value_q;
	logic [mhpq_pkg::CNT_W-1:0] m_count_q;
	mhpq_pkg::status_t      m_status_q;

	// input fields
	mhpq_pkg::cmd_t             in_cmd;
	mhpq_pkg::key_t             in_key;
	logic [mhpq_pkg::POS_W-1:0] in_pos;
	mhpq_pkg::status_t          in_status;
	logic                       s_fire;
	logic                       out_free;

	// decoded conditions
	logic [AW-1:0]   parent_idx;
	logic [LW-1:0]   left_pos;
	logic [LW-1:0]   right_pos;
	logic [LW-1:0]   cnt_l;
	logic [CMPW-1:0] cnt_ext;
	logic [CMPW-1:0] pos_ext;
	logic            idx_zero;
	logic            key_gt_a;
	logic            no_left;
	logic            right_ok;
	logic            take_right;
	mhpq_pkg::key_t  child_val;
	logic [LW-1:0]   child_pos;
	logic            child_gt;

	assign uw       = mhpq_pkg::ucode(step_q);
	assign step_inc = step_q + mhpq_pkg::step_t'(1);

	assign in_cmd = mhpq_pkg::cmd_t'(s_tuser);
	assign in_key = s_tdata[31:0];
	assign in_pos = s_tdata[38:32];

	// input is taken only while the sequencer waits at its idle step
	assign s_tready = (step_q == mhpq_pkg::STEP_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign cnt_ext = CMPW'(cnt_q);
	assign pos_ext = CMPW'(in_pos);

	// reject full, empty and out-of-range requests before any work starts
	always_comb begin
		in_status = mhpq_pkg::STATUS_OK;
		case (in_cmd)
			mhpq_pkg::CMD_INSERT: begin
				if (cnt_q >= DEPTH_C) in_status = mhpq_pkg::STATUS_FULL;
			end
			mhpq_pkg::CMD_EXTRACT, mhpq_pkg::CMD_PEEK: begin
				if (cnt_q == '0) in_status = mhpq_pkg::STATUS_EMPTY;
			end
			mhpq_pkg::CMD_SETKEY: begin
				if (pos_ext == '0 || pos_ext > cnt_ext) in_status = mhpq_pkg::STATUS_BADPOS;
			end
			default: in_status = mhpq_pkg::STATUS_OK;
		endcase
	end

	// tree arithmetic on the current hole position
	assign parent_idx = (idx_q - AW'(1)) >> 1;
	assign left_pos   = {1'b0, idx_q, 1'b1};
	assign right_pos  = left_pos + LW'(1);
	assign cnt_l      = LW'(cnt_q);
	assign idx_zero   = (idx_q == '0);
	assign key_gt_a   = (key_q > rd_a_q);
	assign no_left    = (left_pos >= cnt_l);
	assign right_ok   = (right_pos < cnt_l);
	// ties between the children go right
	assign take_right = right_ok && !(rd_a_q > rd_b_q);
	assign child_val  = take_right ? rd_b_q : rd_a_q;
	assign child_pos  = take_right ? right_pos : left_pos;
	assign child_gt   = (child_val > key_q);

	// read address selection
	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (uw.rd)
			mhpq_pkg::RD_NONE: begin
				rd_addr_a = '0;
				rd_addr_b = '0;
			end
			mhpq_pkg::RD_ROOT: begin
				rd_addr_a = '0;
			end
			mhpq_pkg::RD_ROOT_LAST: begin
				rd_addr_a = '0;
				rd_addr_b = AW'(cnt_q - CW'(1));
			end
			mhpq_pkg::RD_PARENT: begin
				rd_addr_a = parent_idx;
			end
			mhpq_pkg::RD_CHILDREN: begin
				rd_addr_a = left_pos[AW-1:0];
				rd_addr_b = right_pos[AW-1:0];
			end
			default: begin
				rd_addr_a = '0;
				rd_addr_b = '0;
			end
		endcase
	end

	// write port: the moving key travels in key_q, and the hole is filled on each move
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = key_q;
		case (uw.op)
			mhpq_pkg::OP_UP_STEP: begin
				mem_we    = key_gt_a;
				mem_wdata = rd_a_q;
			end
			mhpq_pkg::OP_DOWN_STEP: begin
				mem_we    = child_gt;
				mem_wdata = child_val;
			end
			mhpq_pkg::OP_WRITE_KEY: begin
				mem_we = 1'b1;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// next step: jump on the selected condition, else advance
	always_comb begin
		step_nx = step_inc;
		case (uw.br)
			mhpq_pkg::BR_NEXT:     step_nx = step_inc;
			mhpq_pkg::BR_ALWAYS:   step_nx = uw.target;
			mhpq_pkg::BR_IDX_ZERO: step_nx = idx_zero ? uw.target : step_inc;
			mhpq_pkg::BR_KEY_GT_A: step_nx = key_gt_a ? uw.target : step_inc;
			mhpq_pkg::BR_NO_LEFT:  step_nx = no_left ? uw.target : step_inc;
			mhpq_pkg::BR_CHILD_GT: step_nx = child_gt ? uw.target : step_inc;
			mhpq_pkg::BR_DISPATCH: begin
				// hold at idle; go straight to the result on a rejected command
				if (!s_fire) begin
					step_nx = step_q;
				end else if (in_status != mhpq_pkg::STATUS_OK) begin
					step_nx = mhpq_pkg::STEP_OUT;
				end else begin
					step_nx = mhpq_pkg::cmd_entry(in_cmd);
				end
			end
			mhpq_pkg::BR_EMIT:     step_nx = out_free ? uw.target : step_q;
			default:               step_nx = mhpq_pkg::STEP_IDLE;
		endcase
	end

	// control state: step counter, element count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= mhpq_pkg::STEP_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			step_q <= step_nx;
			case (uw.op)
				mhpq_pkg::OP_INS_START: cnt_q <= cnt_q + CW'(1);
				mhpq_pkg::OP_EXT_START: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
			if (uw.op == mhpq_pkg::OP_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (uw.op)
			mhpq_pkg::OP_ACCEPT: begin
				if (s_fire) begin
					key_q    <= in_key;
					pos_q    <= in_pos;
					status_q <= in_status;
					value_q  <= '0;
				end
			end
			mhpq_pkg::OP_INS_START: begin
				idx_q <= AW'(cnt_q);
			end
			mhpq_pkg::OP_UP_STEP: begin
				if (key_gt_a) idx_q <= parent_idx;
			end
			mhpq_pkg::OP_LOAD_VALUE: begin
				value_q <= rd_a_q;
			end
			mhpq_pkg::OP_EXT_START: begin
				idx_q <= '0;
			end
			mhpq_pkg::OP_EXT_LOAD: begin
				// root leaves as the result; the last key moves to the root
				value_q <= rd_a_q;
				key_q   <= rd_b_q;
			end
			mhpq_pkg::OP_SET_START: begin
				idx_q <= AW'(pos_q - mhpq_pkg::POS_W'(1));
			end
			mhpq_pkg::OP_DOWN_STEP: begin
				if (child_gt) idx_q <= child_pos[AW-1:0];
			end
			mhpq_pkg::OP_EMIT: begin
				if (out_free) begin
					m_value_q  <= value_q;
					m_status_q <= status_q;
					m_count_q  <= cnt_ext[mhpq_pkg::CNT_W-1:0];
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_count_q, m_value_q};
	assign m_tuser  = m_status_q;

endmodule

### test/testbench.sv
// Self-checking testbench for the max-heap priority queue: heap predictor, scoreboard and stimulus.

typedef struct {
	mhpq_pkg::key_t value;
	logic [1:0]     status;
	logic [6:0]     count;
} heap_reply_t;

// Tracks the heap contents from accepted commands and checks each reply in order.
class heap_scoreboard;
	localparam int unsigned SLOTS = mhpq_pkg::DEPTH;

	mhpq_pkg::key_t keys[SLOTS];
	int unsigned held;
	heap_reply_t replies_due[$];
	int unsigned errors;
	int unsigned cmd_seen[4];
	int unsigned status_seen[4];
	int unsigned peak_held;
	int unsigned replies_checked;

	function new();
		held = 0;
		errors = 0;
		peak_held = 0;
		replies_checked = 0;
		foreach (cmd_seen[i]) cmd_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	function void swap_keys(int unsigned a, int unsigned b);
		mhpq_pkg::key_t t;
		t = keys[a];
		keys[a] = keys[b];
		keys[b] = t;
	endfunction

	// Climb while strictly greater than the parent.
	function void float_up(int unsigned i);
		int unsigned p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!(keys[i] > keys[p]))
				break;
			swap_keys(i, p);
			i = p;
		end
	endfunction

	// Descend toward the larger child; on a tie take the right one.
	function void sink_down(int unsigned i);
		int unsigned l;
		int unsigned r;
		int unsigned c;
		while (i < held) begin
			l = 2 * i + 1;
			r = l + 1;
			if (l >= held)
				break;
			c = (r < held && !(keys[l] > keys[r])) ? r : l;
			if (!(keys[c] > keys[i]))
				break;
			swap_keys(c, i);
			i = c;
		end
	endfunction

	// Apply an accepted command to the predicted heap and queue its reply.
	function void note_command(mhpq_pkg::cmd_t cmd, mhpq_pkg::key_t key, logic [6:0] pos);
		heap_reply_t rep;
		int unsigned idx;
		rep.value = '0;
		rep.status = mhpq_pkg::STATUS_OK;
		case (cmd)
			mhpq_pkg::CMD_INSERT: begin
				if (held >= SLOTS) begin
					rep.status = mhpq_pkg::STATUS_FULL;
				end else begin
					keys[held] = key;
					held++;
					float_up(held - 1);
				end
			end
			mhpq_pkg::CMD_EXTRACT: begin
				if (held == 0) begin
					rep.status = mhpq_pkg::STATUS_EMPTY;
				end else begin
					rep.value = keys[0];
					held--;
					keys[0] = keys[held];
					sink_down(0);
				end
			end
			mhpq_pkg::CMD_PEEK: begin
				if (held == 0)
					rep.status = mhpq_pkg::STATUS_EMPTY;
				else
					rep.value = keys[0];
			end
			default: begin
				if (pos == 0 || pos > held) begin
					rep.status = mhpq_pkg::STATUS_BADPOS;
				end else begin
					idx = pos - 1;
					keys[idx] = key;
					if (idx > 0 && key > keys[(idx - 1) / 2])
						float_up(idx);
					else
						sink_down(idx);
				end
			end
		endcase
		rep.count = held[6:0];
		if (held > peak_held)
			peak_held = held;
		cmd_seen[cmd]++;
		status_seen[rep.status]++;
		replies_due.push_back(rep);
	endfunction

	// Compare one reply transfer with the oldest prediction.
	function void check_reply(mhpq_pkg::key_t value, logic [1:0] status, logic [6:0] count);
		heap_reply_t rep;
		if (replies_due.size() == 0) begin
			$display("%0t: unexpected reply value=%0d status=%0d count=%0d",
				$time, value, status, count);
			errors++;
			return;
		end
		rep = replies_due.pop_front();
		replies_checked++;
		if (value !== rep.value) begin
			$display("%0t: value mismatch: expected %0d, got %0d", $time, rep.value, value);
			errors++;
		end
		if (status !== rep.status) begin
			$display("%0t: status mismatch: expected %0d, got %0d", $time, rep.status, status);
			errors++;
		end
		if (count !== rep.count) begin
			$display("%0t: count mismatch: expected %0d, got %0d", $time, rep.count, count);
			errors++;
		end
	endfunction

	function int unsigned outstanding();
		return replies_due.size();
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH        = mhpq_pkg::DEPTH;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned SETTLE       = 30;   // above the longest set-key latency

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	heap_scoreboard sb;
	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	bit             hold_req;
	int unsigned    cycle_count;

	max_heap_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = mhpq_pkg::CMD_INSERT;
		m_tready = 1'b0;
		hold_req = 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 67;
		cycle_count = 0;
	end

	always #5 clk = ~clk;

	// Bound the run; a hang is a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, sb.outstanding());
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random ready, plus a long hold-off counted here when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check every reply transfer against the prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_reply(m_tdata[31:0], m_tuser, m_tdata[38:32]);
	end

	// Offer one command, with random idle cycles first, and wait for its transfer.
	// Record it in the scoreboard here so that the next pick sees the updated fill.
	task automatic send_cmd(mhpq_pkg::cmd_t cmd, mhpq_pkg::key_t key, logic [6:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pos, key};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(cmd, key, pos);
	endtask

	// Drop valid and hold until every predicted reply has arrived.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic mhpq_pkg::key_t pick_key();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return $urandom;
		if (sel < 80)
			return int'($urandom_range(15)) - 8;   // narrow range: many ties
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh7ffffffe;
			3: return 32'sh80000001;
			4: return '0;
			default: return -1;
		endcase
	endfunction

	// Mostly a position inside the heap, sometimes anything the field holds.
	function automatic logic [6:0] pick_pos();
		if (sb.held > 0 && $urandom_range(99) < 80)
			return 7'($urandom_range(sb.held, 1));
		return 7'($urandom_range(127));
	endfunction

	function automatic mhpq_pkg::cmd_t pick_cmd(int unsigned ins_pct, int unsigned ext_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (r < ins_pct)
			return mhpq_pkg::CMD_INSERT;
		if (r < ins_pct + ext_pct)
			return mhpq_pkg::CMD_EXTRACT;
		if (r < ins_pct + ext_pct + 10)
			return mhpq_pkg::CMD_PEEK;
		return mhpq_pkg::CMD_SETKEY;
	endfunction

	// Random traffic in segments that lean toward growing, shrinking or neither.
	task automatic run_random(int unsigned items);
		int unsigned ins_pct;
		int unsigned ext_pct;
		for (int unsigned i = 0; i < items; i++) begin
			if (i % 60 == 0) begin
				case ($urandom_range(2))
					0: begin ins_pct = 75; ext_pct = 10; end
					1: begin ins_pct = 10; ext_pct = 70; end
					default: begin ins_pct = 35; ext_pct = 35; end
				endcase
			end
			send_cmd(pick_cmd(ins_pct, ext_pct), pick_key(), pick_pos());
		end
	endtask

	// Fill past capacity, rewrite deep positions, then drain past empty.
	task automatic fill_and_empty();
		repeat (DEPTH + 2) send_cmd(mhpq_pkg::CMD_INSERT, pick_key(), '0);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sh7fffffff, 7'd64);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sh80000000, 7'd64);
		repeat (4) send_cmd(mhpq_pkg::CMD_SETKEY, pick_key(), 7'($urandom_range(64, 33)));
		send_cmd(mhpq_pkg::CMD_SETKEY, pick_key(), 7'd65);
		repeat (DEPTH + 2) send_cmd(mhpq_pkg::CMD_EXTRACT, pick_key(), pick_pos());
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-heap errors, extreme and tied keys, bad positions, sift both ways.
		send_cmd(mhpq_pkg::CMD_PEEK, '0, '0);
		send_cmd(mhpq_pkg::CMD_EXTRACT, '0, '0);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sd9, 7'd1);
		send_cmd(mhpq_pkg::CMD_INSERT, '0, '0);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sh7fffffff, 7'h7f);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sh80000000, '0);
		send_cmd(mhpq_pkg::CMD_INSERT, -1, '0);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd5, '0);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd5, '0);
		send_cmd(mhpq_pkg::CMD_PEEK, '0, '0);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sd1, 7'd0);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sd1, 7'd127);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sd1, 7'd7);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sh7fffffff, 7'd6);
		send_cmd(mhpq_pkg::CMD_SETKEY, 32'sh80000000, 7'd1);
		repeat (7) send_cmd(mhpq_pkg::CMD_EXTRACT, '0, '0);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd3, '0);

		// Slow receiver; hold it off while inserts keep coming so the block backs up.
		hold_req = 1'b1;
		repeat (20) send_cmd(mhpq_pkg::CMD_INSERT, pick_key(), '0);
		run_random(300);
		wait_drained();

		// Slow sender, mostly ready receiver.
		send_idle_pct = 67;
		recv_idle_pct = 34;
		run_random(300);
		wait_drained();

		// Back to back.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_and_empty();
		run_random(160);

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (sb.outstanding() != 0) begin
			$display("%0t: %0d predicted replies never arrived", $time, sb.outstanding());
			sb.errors++;
		end
		$display("covered %0d replies: insert %0d, extract %0d, peek %0d, set-key %0d",
			sb.replies_checked, sb.cmd_seen[mhpq_pkg::CMD_INSERT],
			sb.cmd_seen[mhpq_pkg::CMD_EXTRACT], sb.cmd_seen[mhpq_pkg::CMD_PEEK],
			sb.cmd_seen[mhpq_pkg::CMD_SETKEY]);
		$display("outcomes ok %0d, empty %0d, full %0d, bad position %0d; peak fill %0d; %0d errors",
			sb.status_seen[mhpq_pkg::STATUS_OK], sb.status_seen[mhpq_pkg::STATUS_EMPTY],
			sb.status_seen[mhpq_pkg::STATUS_FULL], sb.status_seen[mhpq_pkg::STATUS_BADPOS],
			sb.peak_held, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
